// ===== rtl/core/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and helper functions shared by the JSON string
// escaper front end, engine and result queue.
// ----------------------------------------------------------------------------
package jse_pkg;

   // One input beat as it travels from the front end to the engine.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
      logic       is_nul;
   } req_item_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       string_done;
      logic       truncated;
   } rsp_type;

   // Work buffer: byte 0 sits in the low bits.
   typedef logic [3:0][7:0] hold_type;

   // Emission kinds.
   localparam logic [1:0] EMIT_COPY = 2'd0;  // copy emit_data[0 .. len-1]
   localparam logic [1:0] EMIT_ESC2 = 2'd1;  // backslash + emit_data[0]
   localparam logic [1:0] EMIT_HEX  = 2'd2;  // \u00xx of emit_data[0]

   localparam logic [2:0] ESC2_LEN = 3'd2;
   localparam logic [2:0] HEX_LEN  = 3'd6;

   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

   // Length of a UTF-8 sequence started by a valid lead byte, else 0.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b inside {[8'hc2:8'hdf]}) n = 3'd2;
      else if (b inside {[8'he0:8'hef]}) n = 3'd3;
      else if (b inside {[8'hf0:8'hf4]}) n = 3'd4;
      return n;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   // Well-formedness of a complete sequence of length n held in h.
   function automatic logic seq_ok(input hold_type h, input logic [2:0] n);
      logic ok;
      logic [7:0] a;
      logic [7:0] b;
      a  = h[0];
      b  = h[1];
      ok = is_cont(b);
      if (n >= 3'd3) begin
         ok = ok && is_cont(h[2]);
         ok = ok && !(a == 8'he0 && b < 8'ha0);
         ok = ok && !(a == 8'hed && b >= 8'ha0);
      end
      if (n == 3'd4) begin
         ok = ok && !(a == 8'hf0 && b < 8'h90);
         ok = ok && !(a == 8'hf4 && b >= 8'h90);
         ok = ok && is_cont(h[3]);
      end
      return ok;
   endfunction

   // Second character of a two-character escape, or 0 if none applies.
   function automatic logic [7:0] short_escape(input logic [7:0] b);
      logic [7:0] e;
      case (b)
         CH_QUOTE:  e = CH_QUOTE;
         CH_BSLASH: e = CH_BSLASH;
         8'h08:     e = CH_B;
         8'h0c:     e = CH_F;
         8'h0a:     e = CH_N;
         8'h0d:     e = CH_R;
         8'h09:     e = CH_T;
         default:   e = 8'h00;
      endcase
      return e;
   endfunction

   // Lowercase hex digit.
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) d = CH_ZERO + {4'b0, nib};
      else d = 8'h57 + {4'b0, nib};
      return d;
   endfunction

   function automatic logic [7:0] emit_byte(input logic [1:0] kind,
                                            input logic [2:0] idx,
                                            input hold_type  data);
      logic [7:0] o;
      o = data[0];
      case (kind)
         EMIT_COPY: o = data[idx[1:0]];
         EMIT_ESC2: o = (idx == 3'd0) ? CH_BSLASH : data[0];
         EMIT_HEX: begin
            case (idx)
               3'd0:    o = CH_BSLASH;
               3'd1:    o = CH_U;
               3'd2:    o = CH_ZERO;
               3'd3:    o = CH_ZERO;
               3'd4:    o = hex_digit(data[0][7:4]);
               default: o = hex_digit(data[0][3:0]);
            endcase
         end
         default: o = data[0];
      endcase
      return o;
   endfunction

endpackage

// ===== rtl/core/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front
// Input queue: takes request beats, tags NUL terminators, hands them to the
// engine in order.
// ----------------------------------------------------------------------------
module jse_front #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_is_last,
   output logic                 item_valid,
   output jse_pkg::req_item_type item,
   input  logic                 item_pop
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   jse_pkg::req_item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;
   jse_pkg::req_item_type new_item;

   assign req_full   = count_ff == CW'(DEPTH);
   assign item_valid = count_ff != '0;
   assign item       = mem_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      new_item.in_byte = req_in_byte;
      new_item.is_last = req_is_last;
      new_item.is_nul  = req_in_byte == 8'h00;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/core/jse_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// jse_rsp_fifo
// Result queue between the engine and the response port.
// ----------------------------------------------------------------------------
module jse_rsp_fifo #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jse_pkg::rsp_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output jse_pkg::rsp_type head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   jse_pkg::rsp_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/jse_engine.sv =====
// ----------------------------------------------------------------------------
// jse_engine
// Back end: holds pending UTF-8 bytes, decides one byte per step, emits escaped bytes
// one per cycle while the result queue is not full, marks each input beat's last result.
// ----------------------------------------------------------------------------
module jse_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  jse_pkg::req_item_type item,
   output logic                 item_pop,
   output logic                 rsp_push,
   output jse_pkg::rsp_type     rsp_data,
   input  logic                 rsp_full
);

   // Work buffer: [0 .. pos-1] pending sequence, [pos .. cnt-1] not yet seen.
   jse_pkg::hold_type hold_ff, hold_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] pos_ff, pos_in;
   logic [2:0] need_ff, need_in;

   logic active_ff, active_in;
   logic last_ff, last_in;
   logic nul_ff, nul_in;
   logic done_sent_ff, done_sent_in;

   logic              emit_on_ff, emit_on_in;
   logic [1:0]        emit_kind_ff, emit_kind_in;
   logic [2:0]        emit_idx_ff, emit_idx_in;
   logic [2:0]        emit_len_ff, emit_len_in;
   jse_pkg::hold_type emit_data_ff, emit_data_in;

   // One result is held back until we know whether it closes the beat.
   logic             stg_valid_ff, stg_valid_in;
   jse_pkg::rsp_type stg_ff, stg_in;

   logic             step_en;
   logic             prod;
   jse_pkg::rsp_type prod_data;
   logic [7:0]       cur;
   logic [7:0]       esc;
   logic [2:0]       llen;
   logic [2:0]       pos_nx;

   assign step_en = !rsp_full;
   assign cur     = hold_ff[pos_ff];
   assign esc     = jse_pkg::short_escape(cur);
   assign llen    = jse_pkg::lead_len(cur);
   assign pos_nx  = {1'b0, pos_ff} + 3'd1;

   always_comb begin
      hold_in      = hold_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      need_in      = need_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      nul_in       = nul_ff;
      done_sent_in = done_sent_ff;
      emit_on_in   = emit_on_ff;
      emit_kind_in = emit_kind_ff;
      emit_idx_in  = emit_idx_ff;
      emit_len_in  = emit_len_ff;
      emit_data_in = emit_data_ff;
      stg_valid_in = stg_valid_ff;
      stg_in       = stg_ff;
      item_pop     = 1'b0;
      rsp_push     = 1'b0;
      rsp_data     = stg_ff;
      prod         = 1'b0;
      prod_data    = '0;

      if (step_en) begin
         if (!active_ff) begin
            if (item_valid) begin
               item_pop     = 1'b1;
               active_in    = 1'b1;
               last_in      = item.is_last;
               nul_in       = item.is_nul;
               done_sent_in = 1'b0;
               if (!item.is_nul) begin
                  hold_in[cnt_ff[1:0]] = item.in_byte;
                  cnt_in               = cnt_ff + 3'd1;
               end
            end
         end else if (emit_on_ff) begin
            prod                 = 1'b1;
            prod_data.out_byte   = jse_pkg::emit_byte(emit_kind_ff, emit_idx_ff,
                                                      emit_data_ff);
            prod_data.byte_valid = 1'b1;
            emit_idx_in          = emit_idx_ff + 3'd1;
            if (emit_idx_ff + 3'd1 == emit_len_ff) emit_on_in = 1'b0;
         end else if ({1'b0, pos_ff} != cnt_ff) begin
            emit_idx_in = 3'd0;
            if (pos_ff == 2'd0) begin
               if (llen != 3'd0) begin
                  // lead byte: start a pending sequence
                  need_in = llen;
                  pos_in  = 2'd1;
               end else begin
                  emit_on_in   = 1'b1;
                  emit_data_in = {24'h0, (esc != 8'h00) ? esc : cur};
                  if (esc != 8'h00) begin
                     emit_kind_in = jse_pkg::EMIT_ESC2;
                     emit_len_in  = jse_pkg::ESC2_LEN;
                  end else if (cur inside {[8'h20:8'h7e]}) begin
                     emit_kind_in = jse_pkg::EMIT_COPY;
                     emit_len_in  = 3'd1;
                  end else begin
                     emit_kind_in = jse_pkg::EMIT_HEX;
                     emit_len_in  = jse_pkg::HEX_LEN;
                  end
                  hold_in = hold_ff >> 8;
                  cnt_in  = cnt_ff - 3'd1;
               end
            end else if (pos_nx == need_ff) begin
               emit_on_in = 1'b1;
               if (jse_pkg::seq_ok(hold_ff, need_ff)) begin
                  emit_kind_in = jse_pkg::EMIT_COPY;
                  emit_len_in  = need_ff;
                  emit_data_in = hold_ff;
                  hold_in      = hold_ff >> {need_ff, 3'b000};
                  cnt_in       = cnt_ff - need_ff;
               end else begin
                  // bad sequence: escape the lead, replay the rest
                  emit_kind_in = jse_pkg::EMIT_HEX;
                  emit_len_in  = jse_pkg::HEX_LEN;
                  emit_data_in = {24'h0, hold_ff[0]};
                  hold_in      = hold_ff >> 8;
                  cnt_in       = cnt_ff - 3'd1;
               end
               pos_in  = 2'd0;
               need_in = 3'd0;
            end else begin
               pos_in = pos_nx[1:0];
            end
         end else if ((nul_ff || last_ff) && !done_sent_ff) begin
            prod                  = 1'b1;
            prod_data.string_done = 1'b1;
            prod_data.truncated   = nul_ff ? (cnt_ff != 3'd0) : 1'b1;
            hold_in               = '0;
            cnt_in                = 3'd0;
            pos_in                = 2'd0;
            need_in               = 3'd0;
            done_sent_in          = 1'b1;
         end else begin
            // beat finished: release the held result as its last one
            if (stg_valid_ff) begin
               rsp_push          = 1'b1;
               rsp_data          = stg_ff;
               rsp_data.run_last = 1'b1;
            end
            stg_valid_in = 1'b0;
            active_in    = 1'b0;
         end

         if (prod) begin
            if (stg_valid_ff) begin
               rsp_push = 1'b1;
               rsp_data = stg_ff;
            end
            stg_in       = prod_data;
            stg_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= '0;
         cnt_ff       <= 3'd0;
         pos_ff       <= 2'd0;
         need_ff      <= 3'd0;
         active_ff    <= 1'b0;
         last_ff      <= 1'b0;
         nul_ff       <= 1'b0;
         done_sent_ff <= 1'b0;
         emit_on_ff   <= 1'b0;
         stg_valid_ff <= 1'b0;
      end else begin
         hold_ff      <= hold_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         need_ff      <= need_in;
         active_ff    <= active_in;
         last_ff      <= last_in;
         nul_ff       <= nul_in;
         done_sent_ff <= done_sent_in;
         emit_on_ff   <= emit_on_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      emit_kind_ff <= emit_kind_in;
      emit_idx_ff  <= emit_idx_in;
      emit_len_ff  <= emit_len_in;
      emit_data_ff <= emit_data_in;
      stg_ff       <= stg_in;
   end

   a_buf_bounds: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_ff} <= cnt_ff) && (cnt_ff <= 3'd4))
      else $error("work buffer cursor past fill");

   a_pending_short: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 2'd0) |-> ({1'b0, pos_ff} < need_ff))
      else $error("pending sequence reached its length without a check");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (!stg_valid_ff && !emit_on_ff))
      else $error("engine idle with result or emission outstanding");

   a_idle_all_pending: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> ({1'b0, pos_ff} == cnt_ff))
      else $error("engine idle with unprocessed bytes");

endmodule

// ===== rtl/core/json_string_escape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// json_string_escape_utf8_top - JSON string escaper with UTF-8 validation
// The engine takes a queued beat once the previous one is fully retired. Each
// result waits in a staging register before it enters the result queue; the
// bytes of one escape or sequence follow one per cycle while it is not full.
// Reset: synchronous, active high; clears queues and all pending bytes.
// ----------------------------------------------------------------------------
module json_string_escape_utf8_top #(
   parameter int REQ_DEPTH = 2,   // request queue entries, 2..16
   parameter int RSP_DEPTH = 2    // result queue entries, 2..16
) (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   // result side
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_done,
   output logic       rsp_truncated
);

   // Front end -> engine: a queued request beat, already tagged as NUL or not.
   logic                  item_valid;
   jse_pkg::req_item_type item;
   logic                  item_pop;

   // Engine -> result queue.
   logic             eng_push;
   jse_pkg::rsp_type eng_data;
   logic             rsp_q_full;
   jse_pkg::rsp_type rsp_head;

   // Front end. The request queue lets the producer keep pushing while the
   // engine is busy expanding an earlier beat into an escape sequence.
   jse_front #(
      .DEPTH (REQ_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_in_byte (req_in_byte),
      .req_is_last (req_is_last),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   // Engine. Takes a beat only when the previous one is fully retired, keeps
   // the bytes of an unfinished UTF-8 sequence between beats, and holds each
   // result in a staging register so the final result of a beat can carry
   // run_last. The engine stalls whenever the result queue is full.
   jse_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_push   (eng_push),
      .rsp_data   (eng_data),
      .rsp_full   (rsp_q_full)
   );

   // Result queue. Its head drives the result ports directly; a beat leaves
   // on pop while the queue is not empty.
   jse_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_data),
      .full      (rsp_q_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_out_byte    = rsp_head.out_byte;
   assign rsp_byte_valid  = rsp_head.byte_valid;
   assign rsp_run_last    = rsp_head.run_last;
   assign rsp_string_done = rsp_head.string_done;
   assign rsp_truncated   = rsp_head.truncated;

endmodule

// ===== verif/tb_json_string_escape_utf8_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_escape_utf8_top - self-checking bench for the JSON escaper
// Source bytes go in one beat at a time. A local escaper predicts the output
// beats of each byte, and every popped result beat is checked against the
// oldest prediction. A directed table (literal results where typed) comes first, then
// random traffic: mostly UTF-8 sequences and ASCII, plus cut sequences,
// NULs and raw noise. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_json_string_escape_utf8_top;

   localparam int RAND_BEATS   = 200;   // random source bytes
   localparam int MAX_IDLE     = 17;    // longest gap or stall per beat
   localparam int DRAIN_CYCLES = 16;    // quiet time after the last result
   localparam int N_DIRECTED   = 29;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_FF     = 8'h0c;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LB     = 8'h62;   // b
   localparam logic [7:0] CH_LF_F   = 8'h66;   // f
   localparam logic [7:0] CH_LN     = 8'h6e;   // n
   localparam logic [7:0] CH_LR     = 8'h72;   // r
   localparam logic [7:0] CH_LT     = 8'h74;   // t
   localparam logic [7:0] CH_LU     = 8'h75;   // u
   localparam logic [7:0] PRINT_LO  = 8'h20;
   localparam logic [7:0] PRINT_HI  = 8'h7e;

   // one result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       string_done;
      logic       truncated;
   } esc_beat_type;

   // directed stimulus row; when typed is set, the result is the text
   // (right-justified, zero bytes are padding) optionally followed by a
   // string-close beat
   typedef struct packed {
      logic [7:0]  in_byte;
      logic        is_last;
      logic        typed;
      logic [47:0] text;
      logic        done;
      logic        trunc;
   } dir_row_type;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_push       = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_is_last    = 1'b0;
   logic       rsp_pop        = 1'b0;
   logic       rsp_empty;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_string_done;
   logic       rsp_truncated;

   json_string_escape_utf8_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .req_is_last     (req_is_last),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done),
      .rsp_truncated   (rsp_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // escaper state kept by the bench: bytes of an unfinished UTF-8 sequence
   // -------------------------------------------------------------------------
   logic [7:0] hold_buf [3];
   int         hold_cnt = 0;

   esc_beat_type step_out[$];       // beats caused by the byte being predicted
   esc_beat_type escaped_fifo[$];   // beats still owed by the block
   int           err_cnt  = 0;
   int           pop_hold = 0;
   bit           no_idle  = 1'b0;   // both sides run flat out while set
   dir_row_type  dir_rows [N_DIRECTED];

   function automatic int utf8_span(input logic [7:0] b);
      if (b >= 8'hc2 && b <= 8'hdf) return 2;
      if (b >= 8'he0 && b <= 8'hef) return 3;
      if (b >= 8'hf0 && b <= 8'hf4) return 4;
      return 0;
   endfunction

   function automatic bit is_tail(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   // s holds lead + (span - 1) bytes; rejects overlong, surrogate, > U+10FFFF
   function automatic bit utf8_wellformed(input logic [7:0] s [4], input int n);
      bit ok;
      ok = is_tail(s[1]);
      if (n >= 3) begin
         ok = ok && is_tail(s[2]);
         ok = ok && !(s[0] == 8'he0 && s[1] < 8'ha0);
         ok = ok && !(s[0] == 8'hed && s[1] >= 8'ha0);
      end
      if (n == 4) begin
         ok = ok && is_tail(s[3]);
         ok = ok && !(s[0] == 8'hf0 && s[1] < 8'h90);
         ok = ok && !(s[0] == 8'hf4 && s[1] >= 8'h90);
      end
      return ok;
   endfunction

   function automatic void emit_char(input logic [7:0] b);
      esc_beat_type r;
      r = '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, string_done: 1'b0,
            truncated: 1'b0};
      step_out.push_back(r);
   endfunction

   function automatic void emit_close(input logic trunc);
      esc_beat_type r;
      r = '{out_byte: CH_NUL, byte_valid: 1'b0, run_last: 1'b0, string_done: 1'b1,
            truncated: trunc};
      step_out.push_back(r);
   endfunction

   function automatic void emit_hex(input logic [7:0] b);
      string digits;
      digits = "0123456789abcdef";
      emit_char(CH_BSLASH);
      emit_char(CH_LU);
      emit_char(CH_ZERO);
      emit_char(CH_ZERO);
      emit_char(digits[b[7:4]]);
      emit_char(digits[b[3:0]]);
   endfunction

   function automatic void mark_run_last();
      esc_beat_type r;
      if (step_out.size() != 0) begin
         r = step_out.pop_back();
         r.run_last = 1'b1;
         step_out.push_back(r);
      end
   endfunction

   // Work out the beats one source byte causes and advance the held sequence.
   function automatic void predict_escape(input logic [7:0] b, input logic at_limit);
      logic [7:0] work[$];
      logic [7:0] pend [4];
      logic [7:0] c;
      int         pend_n;
      int         need;
      int         i;
      step_out.delete();
      pend_n = 0;
      need   = 0;
      if (b == CH_NUL) begin
         // NUL closes the string; cut short only if a sequence was pending
         emit_close(hold_cnt != 0);
         hold_cnt = 0;
      end else begin
         for (i = 0; i < hold_cnt; i++) work.push_back(hold_buf[i]);
         work.push_back(b);
         hold_cnt = 0;
         while (work.size() != 0) begin
            c = work.pop_front();
            if (pend_n != 0) begin
               pend[pend_n] = c;
               pend_n++;
               if (pend_n == need) begin
                  if (utf8_wellformed(pend, pend_n)) begin
                     for (i = 0; i < pend_n; i++) emit_char(pend[i]);
                  end else begin
                     // bad sequence: escape the lead, replay what followed it
                     emit_hex(pend[0]);
                     for (i = pend_n - 1; i >= 1; i--) work.push_front(pend[i]);
                  end
                  pend_n = 0;
                  need   = 0;
               end
            end else begin
               case (c)
                  CH_QUOTE, CH_BSLASH: begin
                     emit_char(CH_BSLASH);
                     emit_char(c);
                  end
                  CH_BS: begin
                     emit_char(CH_BSLASH);
                     emit_char(CH_LB);
                  end
                  CH_FF: begin
                     emit_char(CH_BSLASH);
                     emit_char(CH_LF_F);
                  end
                  CH_LF: begin
                     emit_char(CH_BSLASH);
                     emit_char(CH_LN);
                  end
                  CH_CR: begin
                     emit_char(CH_BSLASH);
                     emit_char(CH_LR);
                  end
                  CH_TAB: begin
                     emit_char(CH_BSLASH);
                     emit_char(CH_LT);
                  end
                  default: begin
                     if (c >= PRINT_LO && c <= PRINT_HI) begin
                        emit_char(c);
                     end else if (utf8_span(c) != 0) begin
                        pend[0] = c;
                        pend_n  = 1;
                        need    = utf8_span(c);
                     end else begin
                        emit_hex(c);
                     end
                  end
               endcase
            end
         end
         if (at_limit) begin
            // limit reached: whatever is still pending is dropped
            emit_close(1'b1);
         end else begin
            for (i = 0; i < pend_n; i++) hold_buf[i] = pend[i];
            hold_cnt = pend_n;
         end
      end
      mark_run_last();
   endfunction

   // -------------------------------------------------------------------------
   // request side: log the predicted beats, then push after a random gap
   // -------------------------------------------------------------------------
   task automatic send_beat(input logic [7:0] b, input logic at_limit);
      int gap;
      foreach (step_out[k]) escaped_fifo.push_back(step_out[k]);
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      // push stays high across back-to-back beats
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_in_byte <= b;
      req_is_last <= at_limit;
      req_push    <= 1'b1;
      // full as seen just before the edge decides acceptance at that edge
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // result side: random stall before each pop, check every popped beat
   // -------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         err_cnt++;
      end
   endfunction

   function automatic void check_beat();
      esc_beat_type want;
      if (escaped_fifo.size() == 0) begin
         $display("%0t: result beat with nothing expected, expected none, actual %h %b%b%b%b",
                  $time, rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_string_done,
                  rsp_truncated);
         err_cnt++;
      end else begin
         want = escaped_fifo.pop_front();
         check_field("out_byte", want.out_byte, rsp_out_byte);
         check_field("byte_valid", {7'b0, want.byte_valid}, {7'b0, rsp_byte_valid});
         check_field("run_last", {7'b0, want.run_last}, {7'b0, rsp_run_last});
         check_field("string_done", {7'b0, want.string_done}, {7'b0, rsp_string_done});
         check_field("truncated", {7'b0, want.truncated}, {7'b0, rsp_truncated});
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_beat();
            pop_hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (pop_hold != 0) begin
            pop_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      dir_row_type row;
      logic [7:0]  burst[$];
      logic [7:0]  lead;
      logic        at_limit;
      int          kind;
      int          len;
      int          n;
      int          i;
      int          sent;
      int          burst_cnt;
      // in_byte, is_last, typed, text, done, trunc
      dir_rows = '{
         '{CH_NUL,  1'b0, 1'b1, 48'h0,      1'b1, 1'b0},  // empty string right after reset
         '{8'h41,   1'b0, 1'b1, "A",        1'b0, 1'b0},
         '{CH_QUOTE,  1'b0, 1'b1, "\\\"",   1'b0, 1'b0},
         '{CH_BSLASH, 1'b0, 1'b1, "\\\\",   1'b0, 1'b0},
         '{CH_BS,   1'b0, 1'b1, "\\b",      1'b0, 1'b0},
         '{CH_FF,   1'b0, 1'b1, "\\f",      1'b0, 1'b0},
         '{CH_LF,   1'b0, 1'b1, "\\n",      1'b0, 1'b0},
         '{CH_CR,   1'b0, 1'b1, "\\r",      1'b0, 1'b0},
         '{CH_TAB,  1'b0, 1'b1, "\\t",      1'b0, 1'b0},
         '{8'h01,   1'b0, 1'b1, "\\u0001",  1'b0, 1'b0},  // other control byte
         '{8'h7f,   1'b0, 1'b1, "\\u007f",  1'b0, 1'b0},  // DEL
         '{PRINT_HI, 1'b1, 1'b1, "~",       1'b1, 1'b1},  // limit after output
         '{8'hc0,   1'b0, 1'b1, "\\u00c0",  1'b0, 1'b0},  // never a lead
         '{8'hff,   1'b0, 1'b1, "\\u00ff",  1'b0, 1'b0},
         '{8'hc2,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},  // two-byte form
         '{8'ha9,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'he0,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},  // overlong three-byte
         '{8'h80,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'h80,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'hf4,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},  // above U+10FFFF
         '{8'h90,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'h80,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'h80,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'he2,   1'b0, 1'b1, 48'h0,      1'b0, 1'b0},  // held, nothing out
         '{CH_NUL,  1'b1, 1'b1, 48'h0,      1'b1, 1'b1},  // NUL cuts a sequence
         '{CH_NUL,  1'b1, 1'b1, 48'h0,      1'b1, 1'b0},  // idle NUL beats limit
         '{8'hf0,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'h9f,   1'b0, 1'b0, 48'h0,      1'b0, 1'b0},
         '{8'h98,   1'b1, 1'b1, 48'h0,      1'b1, 1'b1}   // limit cuts a sequence
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table: literal results where typed, predicted elsewhere
      for (i = 0; i < N_DIRECTED; i++) begin
         row = dir_rows[i];
         predict_escape(row.in_byte, row.is_last);
         if (row.typed) begin
            step_out.delete();
            for (n = 5; n >= 0; n--) begin
               if (row.text[8*n +: 8] != CH_NUL) emit_char(row.text[8*n +: 8]);
            end
            if (row.done) emit_close(row.trunc);
            mark_run_last();
         end
         send_beat(row.in_byte, row.is_last);
      end

      // random traffic, built as short bursts
      sent      = 0;
      burst_cnt = 0;
      while (sent < RAND_BEATS) begin
         // switch between stalling and flat-out stretches now and then
         if (burst_cnt % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
         burst_cnt++;
         burst.delete();
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // ASCII incl. controls, quote, backslash, DEL
            burst.push_back(8'($urandom_range(1, 127)));
         end else if (kind < 88) begin
            // UTF-8 sequence; the boundary leads get extra weight
            len = $urandom_range(2, 4);
            case (len)
               2: lead = 8'($urandom_range(8'hc2, 8'hdf));
               3: begin
                  if ($urandom_range(0, 2) == 0)
                     lead = ($urandom_range(0, 1) == 0) ? 8'he0 : 8'hed;
                  else
                     lead = 8'($urandom_range(8'he0, 8'hef));
               end
               default: begin
                  if ($urandom_range(0, 2) == 0)
                     lead = ($urandom_range(0, 1) == 0) ? 8'hf0 : 8'hf4;
                  else
                     lead = 8'($urandom_range(8'hf0, 8'hf4));
               end
            endcase
            burst.push_back(lead);
            // past 75: sequence cut short and followed by any nonzero byte
            n = (kind < 75) ? len - 1 : $urandom_range(0, len - 2);
            for (i = 0; i < n; i++) burst.push_back(8'($urandom_range(8'h80, 8'hbf)));
            if (kind >= 75) burst.push_back(8'($urandom_range(1, 255)));
         end else if (kind < 93) begin
            burst.push_back(CH_NUL);
         end else begin
            burst.push_back(8'($urandom_range(0, 255)));
         end
         foreach (burst[k]) begin
            at_limit = ($urandom_range(0, 15) == 0);
            predict_escape(burst[k], at_limit);
            send_beat(burst[k], at_limit);
         end
         sent += burst.size();
      end
      req_push <= 1'b0;
      no_idle  = 1'b0;

      // drain, then allow for any stray late beats
      while (escaped_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
